// ----- rtl/core/b64c_pkg.sv -----
// Shared types, constants and alphabet functions of the Base64 codec
package b64c_pkg;

  localparam int unsigned MaxRes = 4;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);
  localparam int unsigned AddrW  = 3;

  // word index of the mode register within paddr
  localparam logic RegMode = 1'b0;

  localparam logic       ModeEnc = 1'b0;
  localparam logic       ModeDec = 1'b1;
  localparam logic [7:0] PadChar = 8'h3d;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
    logic       bad;
  } res_t;

  typedef struct packed {
    logic [5:0] bits;
    logic [2:0] cnt;
    logic       pad;
  } st_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } cval_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + w;
    end else if (v < 6'd52) begin
      return 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      return 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      return 8'h2b;
    end else begin
      return 8'h2f;
    end
  endfunction

  function automatic cval_t dec_char(input logic [7:0] c);
    cval_t r;
    r = '0;
    case (c) inside
      [8'h41:8'h5a]: begin
        r.ok  = 1'b1;
        r.val = 6'(c - 8'h41);
      end
      [8'h61:8'h7a]: begin
        r.ok  = 1'b1;
        r.val = 6'(c - 8'h61 + 8'd26);
      end
      [8'h30:8'h39]: begin
        r.ok  = 1'b1;
        r.val = 6'(c - 8'h30 + 8'd52);
      end
      8'h2b: begin
        r.ok  = 1'b1;
        r.val = 6'd62;
      end
      8'h2f: begin
        r.ok  = 1'b1;
        r.val = 6'd63;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/core/b64c_xlate.sv -----
// Per-word translation: results and next bit-accumulator state for one input word
module b64c_xlate (
  input  logic                                 mode,
  input  b64c_pkg::st_t                        st,
  input  logic [7:0]                           data,
  input  logic                                 last,
  output b64c_pkg::res_t [b64c_pkg::MaxRes-1:0] res,
  output logic [b64c_pkg::CntW-1:0]            cnt,
  output b64c_pkg::st_t                        st_nxt
);

  b64c_pkg::cval_t cv;

  function automatic b64c_pkg::res_t chr(input logic [7:0] c);
    b64c_pkg::res_t r;
    r      = '0;
    r.data = c;
    r.has  = 1'b1;
    return r;
  endfunction

  assign cv = b64c_pkg::dec_char(data);

  always_comb begin
    res    = '0;
    cnt    = '0;
    st_nxt = st;
    if (mode == b64c_pkg::ModeEnc) begin
      case (st.cnt)
        3'd2: begin
          res[0] = chr(b64c_pkg::enc_char({st.bits[1:0], data[7:4]}));
          if (last) begin
            res[1] = chr(b64c_pkg::enc_char({data[3:0], 2'b00}));
            res[2] = chr(b64c_pkg::PadChar);
            cnt    = b64c_pkg::CntW'(3);
            st_nxt = '0;
          end else begin
            cnt         = b64c_pkg::CntW'(1);
            st_nxt.bits = {2'b00, data[3:0]};
            st_nxt.cnt  = 3'd4;
            st_nxt.pad  = 1'b0;
          end
        end
        3'd4: begin
          res[0] = chr(b64c_pkg::enc_char({st.bits[3:0], data[7:6]}));
          res[1] = chr(b64c_pkg::enc_char(data[5:0]));
          cnt    = b64c_pkg::CntW'(2);
          st_nxt = '0;
        end
        default: begin
          res[0] = chr(b64c_pkg::enc_char(data[7:2]));
          if (last) begin
            res[1] = chr(b64c_pkg::enc_char({data[1:0], 4'b0000}));
            res[2] = chr(b64c_pkg::PadChar);
            res[3] = chr(b64c_pkg::PadChar);
            cnt    = b64c_pkg::CntW'(4);
            st_nxt = '0;
          end else begin
            cnt         = b64c_pkg::CntW'(1);
            st_nxt.bits = {4'b0000, data[1:0]};
            st_nxt.cnt  = 3'd2;
            st_nxt.pad  = 1'b0;
          end
        end
      endcase
    end else begin
      if (data == b64c_pkg::PadChar) begin
        st_nxt.pad = 1'b1;
      end else if (!cv.ok) begin
        // flagged and dropped, state untouched
        res[0].bad = 1'b1;
        cnt        = b64c_pkg::CntW'(1);
      end else if (!st.pad) begin
        case (st.cnt)
          3'd2: begin
            res[0]      = chr({st.bits[1:0], cv.val});
            cnt         = b64c_pkg::CntW'(1);
            st_nxt.bits = '0;
            st_nxt.cnt  = 3'd0;
          end
          3'd4: begin
            res[0]      = chr({st.bits[3:0], cv.val[5:2]});
            cnt         = b64c_pkg::CntW'(1);
            st_nxt.bits = {4'b0000, cv.val[1:0]};
            st_nxt.cnt  = 3'd2;
          end
          3'd6, 3'd7: begin
            res[0]      = chr({st.bits, cv.val[5:4]});
            cnt         = b64c_pkg::CntW'(1);
            st_nxt.bits = {2'b00, cv.val[3:0]};
            st_nxt.cnt  = 3'd4;
          end
          default: begin
            st_nxt.bits = cv.val;
            st_nxt.cnt  = 3'd6;
          end
        endcase
      end
      if (last) begin
        // empty end marker when nothing else comes out
        if (cnt == '0) begin
          res[0] = '0;
          cnt    = b64c_pkg::CntW'(1);
        end
        st_nxt = '0;
      end
    end
    for (int i = 0; i < b64c_pkg::MaxRes; i++) begin
      if (last && (cnt == b64c_pkg::CntW'(i + 1))) begin
        res[i].last = 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/base64_codec_core.sv -----
// Top level of the streaming Base64 codec
//
// Input channel (in_valid/in_ready) takes one word per handshake: a raw byte
// when encoding, an ASCII character when decoding, with in_last_in on the
// final word of a message. The output channel (out_valid/out_ready) gives
// the results one word per handshake; out_last_out marks the final result of
// a message and out_has_data is low on an empty end marker.
// Each accepted word is translated in the cycle it is accepted and its 0 to
// 4 results are loaded into a small result queue; the first appears on the
// output in the cycle after acceptance. A new word is taken in the cycle the
// last queued result leaves, so the input waits for the queue to empty:
// ordinary encode bytes give 1 to 2 results, decode characters at most 1, up to 4
// for a final encode byte. The result queue is the limit.
// Reset (rst_n low, synchronous) empties the queue, clears the accumulator
// and selects encode mode. A stalled receiver holds the queue and therefore
// the input. The user must write the APB mode register (address 0) only while
// idle, which the block itself does not enforce; writing it also abandons any part-finished message.
module base64_codec_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_in,
  input  logic                       in_last_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_data_out,
  output logic                       out_has_data,
  output logic                       out_last_out,
  output logic                       out_bad_char,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [b64c_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic                                  mode_r;
  b64c_pkg::st_t                         st_r;
  b64c_pkg::st_t                         st_nxt;
  b64c_pkg::res_t [b64c_pkg::MaxRes-1:0] res_r;
  b64c_pkg::res_t [b64c_pkg::MaxRes-1:0] res_nxt;
  logic [b64c_pkg::CntW-1:0]             rem_r;
  logic [b64c_pkg::CntW-1:0]             cnt_nxt;
  logic                                  acc;
  logic                                  pop;
  logic                                  cfg_wr;

  b64c_xlate u_xlate (
    .mode   (mode_r),
    .st     (st_r),
    .data   (in_data_in),
    .last   (in_last_in),
    .res    (res_nxt),
    .cnt    (cnt_nxt),
    .st_nxt (st_nxt)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == b64c_pkg::RegMode);
  assign prdata = (paddr[2] == b64c_pkg::RegMode) ? {31'b0, mode_r} : 32'b0;

  assign out_valid    = (rem_r != '0);
  assign in_ready     = (rem_r == '0) || ((rem_r == b64c_pkg::CntW'(1)) && out_ready);
  assign acc          = in_valid && in_ready;
  assign pop          = out_valid && out_ready;
  assign out_data_out = res_r[0].data;
  assign out_has_data = res_r[0].has;
  assign out_last_out = res_r[0].last;
  assign out_bad_char = res_r[0].bad;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= b64c_pkg::ModeEnc;
      st_r   <= '0;
      rem_r  <= '0;
    end else begin
      if (cfg_wr) begin
        mode_r <= pwdata[0];
        st_r   <= '0;
      end else if (acc) begin
        st_r <= st_nxt;
      end
      if (acc) begin
        rem_r <= cnt_nxt;
      end else if (pop) begin
        rem_r <= rem_r - b64c_pkg::CntW'(1);
      end
    end
  end

  // result queue: loaded whole on accept, shifted down on each pop
  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_nxt;
    end else if (pop) begin
      res_r <= {b64c_pkg::res_t'('0), res_r[b64c_pkg::MaxRes-1:1]};
    end
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= b64c_pkg::CntW'(b64c_pkg::MaxRes))
    else $error("result queue count out of range");

  a_last_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_out) |-> (rem_r == b64c_pkg::CntW'(1)))
    else $error("final result is not the tail of the queue");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_last_in) |=> (st_r == '0))
    else $error("accumulator not cleared after end of message");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_data) |-> (out_data_out == 8'h00))
    else $error("empty result carries data");

  a_drain_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r == '0) |-> in_ready)
    else $error("input stalled with empty queue");

endmodule

// ----- dv/base64_codec_core_checker.sv -----
// Scoreboard for the Base64 codec: tracks the codec state and checks every result word
`timescale 1ns / 1ps
module base64_codec_core_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  logic [7:0]                 in_data_in,
  input  logic                       in_last_in,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  logic [7:0]                 out_data_out,
  input  logic                       out_has_data,
  input  logic                       out_last_out,
  input  logic                       out_bad_char,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [b64c_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  input  logic                       pready,
  output int unsigned                n_fail,
  output int unsigned                n_pending
);

  localparam string Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [b64c_pkg::AddrW-1:0] ModeAddr = {b64c_pkg::RegMode, 2'b00};

  logic           mode_q;
  logic [5:0]     acc_bits;
  int unsigned    acc_cnt;
  logic           pad_seen;
  b64c_pkg::res_t codec_res_q[$];

  function automatic void clear_stream();
    acc_bits = '0;
    acc_cnt  = 0;
    pad_seen = 1'b0;
  endfunction

  function automatic b64c_pkg::res_t mk_res(input logic [7:0] d, input logic has,
                                            input logic bad);
    b64c_pkg::res_t r;
    r.data = d;
    r.has  = has;
    r.last = 1'b0;
    r.bad  = bad;
    return r;
  endfunction

  function automatic int b64_value(input logic [7:0] c);
    for (int i = 0; i < 64; i++) begin
      if (Alphabet[i] == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic int unsigned low_mask(input int unsigned nbits);
    return (32'd1 << nbits) - 32'd1;
  endfunction

  // works out the result words one input word causes and queues them
  function automatic void translate_word(input logic [7:0] d, input logic lst);
    b64c_pkg::res_t out_w[$];
    int unsigned    acc;
    int unsigned    total;
    int unsigned    n;
    int unsigned    pads;
    int             v;
    if (mode_q == b64c_pkg::ModeEnc) begin
      n     = (acc_cnt > 4) ? 0 : acc_cnt;
      acc   = ((32'(acc_bits) & low_mask(n)) << 8) | 32'(d);
      total = n + 8;
      while (total >= 6) begin
        total -= 6;
        out_w = {out_w, mk_res(Alphabet[(acc >> total) & 63], 1'b1, 1'b0)};
      end
      acc &= low_mask(total);
      if (lst) begin
        if (total > 0) begin
          // one byte left in the group gives two pad chars, two bytes give one
          pads  = (total == 2) ? 2 : 1;
          out_w = {out_w, mk_res(Alphabet[(acc << (6 - total)) & 63], 1'b1, 1'b0)};
          repeat (pads) out_w = {out_w, mk_res(b64c_pkg::PadChar, 1'b1, 1'b0)};
        end
        clear_stream();
      end else begin
        acc_bits = 6'(acc);
        acc_cnt  = total;
      end
    end else begin
      v = b64_value(d);
      if (d == b64c_pkg::PadChar) begin
        pad_seen = 1'b1;
      end else if (v < 0) begin
        out_w = {out_w, mk_res(8'h00, 1'b0, 1'b1)};
      end else if (!pad_seen) begin
        n     = (acc_cnt > 6) ? 6 : acc_cnt;
        acc   = ((32'(acc_bits) & low_mask(n)) << 6) | 32'(v);
        total = n + 6;
        if (total >= 8) begin
          total -= 8;
          out_w = {out_w, mk_res(8'(acc >> total), 1'b1, 1'b0)};
        end
        acc_bits = 6'(acc & low_mask(total));
        acc_cnt  = total;
      end
      if (lst) begin
        // nothing produced on the final char: empty end marker
        if (out_w.size() == 0) begin
          out_w = {out_w, mk_res(8'h00, 1'b0, 1'b0)};
        end
        clear_stream();
      end
    end
    if (lst && out_w.size() > 0) begin
      out_w[out_w.size() - 1].last = 1'b1;
    end
    codec_res_q = {codec_res_q, out_w};
  endfunction

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("%0d ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    n_fail++;
  endtask

  task automatic check_result();
    b64c_pkg::res_t got;
    b64c_pkg::res_t want;
    got = {out_data_out, out_has_data, out_last_out, out_bad_char};
    if (codec_res_q.size() == 0) begin
      report_mismatch("unexpected word", 0, 32'(got));
      return;
    end
    want = codec_res_q.pop_front();
    if (got.data !== want.data) report_mismatch("data_out", want.data, got.data);
    if (got.has !== want.has) report_mismatch("has_data", want.has, got.has);
    if (got.last !== want.last) report_mismatch("last_out", want.last, got.last);
    if (got.bad !== want.bad) report_mismatch("bad_char", want.bad, got.bad);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode_q = b64c_pkg::ModeEnc;
      clear_stream();
      codec_res_q.delete();
      n_fail = 0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (in_valid && in_ready) translate_word(in_data_in, in_last_in);
      // a mode write drops any half-finished message
      if (psel && penable && pwrite && pready && paddr == ModeAddr) begin
        mode_q = pwdata[0];
        clear_stream();
      end
    end
    n_pending <= codec_res_q.size();
  end

endmodule

// ----- dv/base64_codec_core_tb.sv -----
// Testbench top for the Base64 codec: stimulus, handshake idling, watchdog and verdict
`timescale 1ns / 1ps
module base64_codec_core_tb;

  localparam string Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
  localparam logic [b64c_pkg::AddrW-1:0] ModeAddr = {b64c_pkg::RegMode, 2'b00};
  localparam int unsigned IdleLimit    = 2000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseWords   = 150;

  logic                       clk        = 1'b0;
  logic                       rst_n      = 1'b0;
  logic                       in_valid   = 1'b0;
  logic [7:0]                 in_data_in = '0;
  logic                       in_last_in = 1'b0;
  logic                       out_ready  = 1'b0;
  logic                       psel       = 1'b0;
  logic                       penable    = 1'b0;
  logic                       pwrite     = 1'b0;
  logic [b64c_pkg::AddrW-1:0] paddr      = '0;
  logic [31:0]                pwdata     = '0;

  logic        in_ready;
  logic        out_valid;
  logic [7:0]  out_data_out;
  logic        out_has_data;
  logic        out_last_out;
  logic        out_bad_char;
  logic [31:0] prdata;
  logic        pready;

  int unsigned n_fail;
  int unsigned n_pending;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned idle_run    = 0;
  int unsigned words_sent  = 0;
  logic        cur_mode    = b64c_pkg::ModeEnc;
  logic [7:0]  msg_q[$];

  base64_codec_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_in  (in_data_in),
    .in_last_in  (in_last_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data_out(out_data_out),
    .out_has_data(out_has_data),
    .out_last_out(out_last_out),
    .out_bad_char(out_bad_char),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  base64_codec_core_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data_in  (in_data_in),
    .in_last_in  (in_last_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data_out(out_data_out),
    .out_has_data(out_has_data),
    .out_last_out(out_last_out),
    .out_bad_char(out_bad_char),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .n_fail      (n_fail),
    .n_pending   (n_pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_run <= 0;
    end else begin
      idle_run <= idle_run + 1;
      if (idle_run >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // valid stays up between back-to-back words; it is dropped only for an idle gap or when draining
  task automatic send_word(input logic [7:0] d, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data_in <= d;
    in_last_in <= lst;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic send_msg(input bit close);
    foreach (msg_q[i]) send_word(msg_q[i], close && (i == msg_q.size() - 1));
  endtask

  task automatic load_str(input string s);
    msg_q.delete();
    for (int i = 0; i < s.len(); i++) msg_q = {msg_q, s[i]};
  endtask

  // hold off until every queued result word has been taken
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ModeAddr;
    pwdata  <= {31'b0, m};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    cur_mode = m;
  endtask

  task automatic run_directed();
    set_mode(b64c_pkg::ModeEnc);
    load_str("M");
    send_msg(1'b1);
    load_str("Ma");
    send_msg(1'b1);
    load_str("Man");
    send_msg(1'b1);
    msg_q = '{8'hff, 8'hff, 8'hff};
    send_msg(1'b1);
    msg_q = '{8'hfb, 8'hef, 8'hbe};
    send_msg(1'b1);
    // unfinished message, abandoned by the mode change
    load_str("x");
    send_msg(1'b0);
    set_mode(b64c_pkg::ModeDec);
    load_str("TWE=");
    send_msg(1'b1);
    // chars after pad are dropped, a stray char is still flagged
    load_str("TQ=Q*=");
    send_msg(1'b1);
    load_str("-");
    send_msg(1'b1);
    load_str("A");
    send_msg(1'b1);
  endtask

  task automatic build_encode_msg();
    int unsigned len;
    msg_q.delete();
    len = $urandom_range(1, 8);
    repeat (len) begin
      if ($urandom_range(3) == 0) begin
        msg_q = {msg_q, ($urandom_range(1) ? 8'hff : 8'h00)};
      end else begin
        msg_q = {msg_q, 8'($urandom_range(255))};
      end
    end
  endtask

  task automatic build_decode_msg();
    int unsigned kind;
    int unsigned groups;
    int unsigned tail;
    int unsigned len;
    msg_q.delete();
    kind = $urandom_range(9);
    if (kind < 7) begin
      groups = $urandom_range(3);
      tail   = $urandom_range(2);
      if (groups == 0 && tail == 0) groups = 1;
      repeat (4 * groups) msg_q = {msg_q, Alphabet[$urandom_range(63)]};
      if (tail == 1) begin
        repeat (2) msg_q = {msg_q, Alphabet[$urandom_range(63)]};
        repeat (2) msg_q = {msg_q, b64c_pkg::PadChar};
      end else if (tail == 2) begin
        repeat (3) msg_q = {msg_q, Alphabet[$urandom_range(63)]};
        msg_q = {msg_q, b64c_pkg::PadChar};
      end
      // occasionally break an otherwise valid message
      if (kind == 6) msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
    end else begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        case ($urandom_range(3))
          0, 1: msg_q = {msg_q, 8'($urandom_range(255))};
          2: msg_q = {msg_q, b64c_pkg::PadChar};
          default: msg_q = {msg_q, Alphabet[$urandom_range(63)]};
        endcase
      end
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned stop;
    bit          close;
    stop = words_sent + n;
    while (words_sent < stop) begin
      if ($urandom_range(9) == 0) begin
        set_mode($urandom_range(1) ? b64c_pkg::ModeDec : b64c_pkg::ModeEnc);
      end
      if (cur_mode == b64c_pkg::ModeEnc) begin
        build_encode_msg();
      end else begin
        build_decode_msg();
      end
      close = ($urandom_range(19) != 0);
      send_msg(close);
      if (!close) set_mode($urandom_range(1) ? b64c_pkg::ModeDec : b64c_pkg::ModeEnc);
    end
  endtask

  initial begin
    tx_idle_pct = 8;
    rx_idle_pct = 56;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random(PhaseWords);
    tx_idle_pct = 56;
    rx_idle_pct = 8;
    run_random(PhaseWords);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(PhaseWords);
    drain();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
